// ----- sv/clti_pkg.sv -----
// clti_pkg: shared widths, register indexes, action codes, reset values and
// saturation limits for the cooling table interpolator; no dependencies
package clti_pkg;

  // field widths
  localparam int DATA_W    = 24;
  localparam int ROW_W     = 3;
  localparam int CFG_IDX_W = 2;

  // internal working widths (cover the whole fraction-bits range)
  localparam int MW      = 28;   // metallicity and temperature offsets
  localparam int XW      = 33;   // twenty times the temperature offset
  localparam int DIFF_W  = 25;   // difference of two table values
  localparam int DEN_W   = 25;   // segment width, and position within it
  localparam int QW      = 26;   // quotient bits of the metallicity divide
  localparam int DW      = DEN_W + 1;
  localparam int NW      = DW + QW;
  localparam int NUM_W   = DEN_W + 1 + DIFF_W;
  localparam int RW      = 28;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [MW-1:0]     metal_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_METAL_FLOOR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOLAR_OFFSET = 2'd1;

  // action codes
  localparam logic ACT_QUERY = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // register reset values
  localparam data_t METAL_FLOOR_RST  = -24'sd1310720;
  localparam data_t SOLAR_OFFSET_RST = -24'sd111411;

  // output saturation limits
  localparam logic signed [RW-1:0] RES_MAX = 28'sd8388607;
  localparam logic signed [RW-1:0] RES_MIN = -28'sd8388608;

endpackage

// ----- sv/cooling_table_interpolator_unit.sv -----
// cooling_table_interpolator_unit: 8-row cooling table with bilinear lookup
// in metallicity and temperature; uses clti_pkg
//
// One word per cycle: start with busy low takes a table write or a query in
// every clock cycle. A query gives its result on out_valid/out_log_cooling
// once it has run through every registered stage; the depth is
// set by the one-bit-per-stage divider that weights the two table rows over
// the metallicity segment. A write takes effect for every query taken after
// it and gives no result. busy is high only during reset, and results cannot
// be held off: the receiver must take each one in its strobe cycle. The table
// sits in four banks split by row and column parity, so the four corners of a
// query are read in the same cycle. Table entries come up undefined; cfg writes are
// taken at any time with cfg_ready always high, and belong in idle periods.
module cooling_table_interpolator_unit #(
  parameter int TEMP_POINTS = 91,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       start,
  output logic                                       busy,
  input  logic                                       in_action,
  input  logic signed [clti_pkg::DATA_W-1:0]         in_log_metal,
  input  logic signed [clti_pkg::DATA_W-1:0]         in_log_temp,
  input  logic [clti_pkg::ROW_W-1:0]                 in_entry_row,
  input  logic [$clog2(TEMP_POINTS)-1:0]             in_entry_column,
  input  logic signed [clti_pkg::DATA_W-1:0]         in_entry_value,
  output logic                                       out_valid,
  output logic signed [clti_pkg::DATA_W-1:0]         out_log_cooling,
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [clti_pkg::CFG_IDX_W-1:0]             cfg_index,
  input  logic [clti_pkg::DATA_W-1:0]                cfg_data
);
  import clti_pkg::*;

  localparam int CW      = $clog2(TEMP_POINTS);
  localparam int HDEPTH  = (TEMP_POINTS + 1) / 2;
  localparam int HW      = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
  localparam int AW      = 2 + HW;
  localparam int BDEPTH  = 1 << AW;
  localparam int ONE_I   = 1 << FRAC_BITS;
  localparam int HALF_I  = 1 << (FRAC_BITS - 1);
  localparam int PW      = FRAC_BITS + 2 + DIFF_W;
  localparam int LATENCY = 11 + QW;

  // breakpoints
  localparam metal_t BP1  = MW'(-3 * ONE_I);
  localparam metal_t BP2  = MW'(-2 * ONE_I);
  localparam metal_t BP3  = MW'(-3 * HALF_I);
  localparam metal_t BP4  = MW'(-ONE_I);
  localparam metal_t BP5  = MW'(-HALF_I);
  localparam metal_t BP6  = '0;
  localparam metal_t BP7  = MW'(HALF_I);
  localparam metal_t FOUR = MW'(4 * ONE_I);

  localparam logic signed [XW-1:0] BIN_ZERO = '0;
  localparam logic signed [XW-1:0] BIN_LAST = XW'(TEMP_POINTS - 1);
  localparam logic [CW-1:0]        COL_TOP  = CW'(TEMP_POINTS - 2);
  localparam logic [CW:0]          COL_LIM  = (CW + 1)'(TEMP_POINTS);
  localparam logic [FRAC_BITS:0]   R_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [DEN_W-1:0]     DEN_UNIT = DEN_W'(1);
  localparam logic signed [PW-1:0] HALF_P   = PW'(HALF_I);
  localparam logic signed [RW-1:0] QOFS     = RW'(1 << (QW - 1));

  // configuration registers
  data_t metal_floor_r, solar_r;
  logic  busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metal_floor_r <= METAL_FLOOR_RST;
      solar_r       <= SOLAR_OFFSET_RST;
      busy_r        <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_METAL_FLOOR:  metal_floor_r <= data_t'(cfg_data);
          CFG_SOLAR_OFFSET: solar_r       <= data_t'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  logic in_acc;
  assign in_acc = start && !busy_r;

  // stage 1: offsets
  logic               s1_v_r, s1_wr_r;
  logic [ROW_W-1:0]   s1_row_r;
  logic [CW-1:0]      s1_col_r;
  data_t              s1_val_r;
  metal_t             s1_rel_r, s1_x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else        s1_v_r <= in_acc;
  end

  always_ff @(posedge clk) begin
    s1_wr_r  <= (in_action == ACT_WRITE);
    s1_row_r <= in_entry_row;
    s1_col_r <= in_entry_column;
    s1_val_r <= in_entry_value;
    s1_rel_r <= MW'(in_log_metal) - MW'(solar_r);
    s1_x_r   <= MW'(in_log_temp) - FOUR;
  end

  // stage 2: segment search, scaled temperature
  metal_t floor_ext;
  logic [2:0] seg_nxt;
  assign floor_ext = MW'(metal_floor_r);

  always_comb begin
    priority if (s1_rel_r <= BP1) seg_nxt = 3'd0;
    else if (s1_rel_r <= BP2)     seg_nxt = 3'd1;
    else if (s1_rel_r <= BP3)     seg_nxt = 3'd2;
    else if (s1_rel_r <= BP4)     seg_nxt = 3'd3;
    else if (s1_rel_r <= BP5)     seg_nxt = 3'd4;
    else if (s1_rel_r <= BP6)     seg_nxt = 3'd5;
    else                          seg_nxt = 3'd6;
  end

  logic                  s2_v_r, s2_wr_r, s2_lo_r, s2_hi_r;
  logic [ROW_W-1:0]      s2_row_r;
  logic [CW-1:0]         s2_col_r;
  data_t                 s2_val_r;
  metal_t                s2_rel_r;
  logic [2:0]            s2_seg_r;
  logic signed [XW-1:0]  s2_x20_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else        s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    s2_wr_r  <= s1_wr_r;
    s2_row_r <= s1_row_r;
    s2_col_r <= s1_col_r;
    s2_val_r <= s1_val_r;
    s2_rel_r <= s1_rel_r;
    s2_seg_r <= seg_nxt;
    s2_lo_r  <= (s1_rel_r <= floor_ext);
    s2_hi_r  <= (s1_rel_r > BP7);
    s2_x20_r <= (XW'(s1_x_r) <<< 4) + (XW'(s1_x_r) <<< 2);
  end

  // stage 3: row pair and weight, column and fraction
  metal_t bp_lo, bp_hi, relw_full, den_full;
  logic [ROW_W-1:0]       row_a_nxt;
  logic [DEN_W-1:0]       relw_nxt, den_nxt;
  logic signed [XW-1:0]   bin;
  logic [CW-1:0]          col_nxt;
  logic [FRAC_BITS:0]     r_nxt;

  always_comb begin
    unique case (s2_seg_r)
      3'd0:    begin bp_lo = floor_ext; bp_hi = BP1; end
      3'd1:    begin bp_lo = BP1;       bp_hi = BP2; end
      3'd2:    begin bp_lo = BP2;       bp_hi = BP3; end
      3'd3:    begin bp_lo = BP3;       bp_hi = BP4; end
      3'd4:    begin bp_lo = BP4;       bp_hi = BP5; end
      3'd5:    begin bp_lo = BP5;       bp_hi = BP6; end
      default: begin bp_lo = BP6;       bp_hi = BP7; end
    endcase
    relw_full = s2_rel_r - bp_lo;
    den_full  = bp_hi - bp_lo;
    // outside the breakpoints a single row: weight zero on row 0, full on row 7
    priority if (s2_lo_r) begin
      row_a_nxt = '0;
      relw_nxt  = '0;
      den_nxt   = DEN_UNIT;
    end else if (s2_hi_r) begin
      row_a_nxt = ROW_W'(6);
      relw_nxt  = DEN_UNIT;
      den_nxt   = DEN_UNIT;
    end else begin
      row_a_nxt = s2_seg_r;
      relw_nxt  = DEN_W'(relw_full);
      den_nxt   = DEN_W'(den_full);
    end
  end

  // clamped bins use the end entry exactly: fraction zero or one
  always_comb begin
    bin = s2_x20_r >>> FRAC_BITS;
    priority if (bin <= BIN_ZERO) begin
      col_nxt = '0;
      r_nxt   = '0;
    end else if (bin >= BIN_LAST) begin
      col_nxt = COL_TOP;
      r_nxt   = R_ONE;
    end else begin
      col_nxt = bin[CW-1:0];
      r_nxt   = {1'b0, s2_x20_r[FRAC_BITS-1:0]};
    end
  end

  logic               s3_v_r, s3_wr_r;
  logic [ROW_W-1:0]   s3_row_r, s3_row_a_r;
  logic [CW-1:0]      s3_col_r, s3_col_lo_r;
  data_t              s3_val_r;
  logic [DEN_W-1:0]   s3_relw_r, s3_den_r;
  logic [FRAC_BITS:0] s3_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else        s3_v_r <= s2_v_r;
  end

  always_ff @(posedge clk) begin
    s3_wr_r     <= s2_wr_r;
    s3_row_r    <= s2_row_r;
    s3_col_r    <= s2_col_r;
    s3_val_r    <= s2_val_r;
    s3_row_a_r  <= row_a_nxt;
    s3_relw_r   <= relw_nxt;
    s3_den_r    <= den_nxt;
    s3_col_lo_r <= col_nxt;
    s3_r_r      <= r_nxt;
  end

  // four table banks by {row parity, column parity}
  logic [ROW_W-1:0] row_b, even_row, odd_row;
  logic [CW-1:0]    col_hi, even_col, odd_col, even_colh, odd_colh, wr_colh;
  logic [AW-1:0]    rd_addr [0:3];
  logic [AW-1:0]    wr_addr;
  logic [1:0]       wr_bank;
  logic             wr_en;
  data_t            rd_data [0:3];

  always_comb begin
    row_b     = s3_row_a_r + ROW_W'(1);
    even_row  = s3_row_a_r[0] ? row_b : s3_row_a_r;
    odd_row   = s3_row_a_r[0] ? s3_row_a_r : row_b;
    col_hi    = s3_col_lo_r + CW'(1);
    even_col  = s3_col_lo_r[0] ? col_hi : s3_col_lo_r;
    odd_col   = s3_col_lo_r[0] ? s3_col_lo_r : col_hi;
    even_colh = even_col >> 1;
    odd_colh  = odd_col >> 1;
    wr_colh   = s3_col_r >> 1;
    rd_addr[0] = {even_row[2:1], HW'(even_colh)};
    rd_addr[1] = {even_row[2:1], HW'(odd_colh)};
    rd_addr[2] = {odd_row[2:1],  HW'(even_colh)};
    rd_addr[3] = {odd_row[2:1],  HW'(odd_colh)};
    wr_addr   = {s3_row_r[2:1], HW'(wr_colh)};
    wr_bank   = {s3_row_r[0], s3_col_r[0]};
    wr_en     = s3_v_r && s3_wr_r && ({1'b0, s3_col_r} < COL_LIM);
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    data_t mem [0:BDEPTH-1];
    data_t rd_r;

    always_ff @(posedge clk) begin
      rd_r <= mem[rd_addr[g]];
      if (wr_en && (wr_bank == 2'(g))) begin
        mem[wr_addr] <= s3_val_r;
      end
    end

    assign rd_data[g] = rd_r;
  end

  // stage 4: table words arrive
  logic               s4_v_r, s4_ra_odd_r, s4_cl_odd_r;
  logic [FRAC_BITS:0] s4_r_r;
  logic [DEN_W-1:0]   s4_relw_r, s4_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else        s4_v_r <= s3_v_r && !s3_wr_r;
  end

  always_ff @(posedge clk) begin
    s4_ra_odd_r <= s3_row_a_r[0];
    s4_cl_odd_r <= s3_col_lo_r[0];
    s4_r_r      <= s3_r_r;
    s4_relw_r   <= s3_relw_r;
    s4_den_r    <= s3_den_r;
  end

  // stage 5: corner routing and column differences
  data_t e_a_lo, e_a_hi, e_b_lo, e_b_hi;

  always_comb begin
    e_a_lo = rd_data[{s4_ra_odd_r,  s4_cl_odd_r}];
    e_a_hi = rd_data[{s4_ra_odd_r, !s4_cl_odd_r}];
    e_b_lo = rd_data[{!s4_ra_odd_r,  s4_cl_odd_r}];
    e_b_hi = rd_data[{!s4_ra_odd_r, !s4_cl_odd_r}];
  end

  logic               s5_v_r;
  data_t              s5_ea_r, s5_eb_r;
  diff_t              s5_da_r, s5_db_r;
  logic [FRAC_BITS:0] s5_r_r;
  logic [DEN_W-1:0]   s5_relw_r, s5_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s5_v_r <= 1'b0;
    else        s5_v_r <= s4_v_r;
  end

  always_ff @(posedge clk) begin
    s5_ea_r   <= e_a_lo;
    s5_eb_r   <= e_b_lo;
    s5_da_r   <= DIFF_W'(e_a_hi) - DIFF_W'(e_a_lo);
    s5_db_r   <= DIFF_W'(e_b_hi) - DIFF_W'(e_b_lo);
    s5_r_r    <= s4_r_r;
    s5_relw_r <= s4_relw_r;
    s5_den_r  <= s4_den_r;
  end

  // stage 6: fraction times difference, both rows
  logic signed [FRAC_BITS+1:0] r_s;
  assign r_s = signed'({1'b0, s5_r_r});

  logic                 s6_v_r;
  logic signed [PW-1:0] s6_pa_r, s6_pb_r;
  data_t                s6_ea_r, s6_eb_r;
  logic [DEN_W-1:0]     s6_relw_r, s6_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s6_v_r <= 1'b0;
    else        s6_v_r <= s5_v_r;
  end

  always_ff @(posedge clk) begin
    s6_pa_r   <= PW'(r_s) * PW'(s5_da_r);
    s6_pb_r   <= PW'(r_s) * PW'(s5_db_r);
    s6_ea_r   <= s5_ea_r;
    s6_eb_r   <= s5_eb_r;
    s6_relw_r <= s5_relw_r;
    s6_den_r  <= s5_den_r;
  end

  // stage 7: row values, round half up
  logic             s7_v_r;
  diff_t            s7_ta_r, s7_tb_r;
  logic [DEN_W-1:0] s7_relw_r, s7_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s7_v_r <= 1'b0;
    else        s7_v_r <= s6_v_r;
  end

  always_ff @(posedge clk) begin
    s7_ta_r   <= DIFF_W'(PW'(s6_ea_r) + ((s6_pa_r + HALF_P) >>> FRAC_BITS));
    s7_tb_r   <= DIFF_W'(PW'(s6_eb_r) + ((s6_pb_r + HALF_P) >>> FRAC_BITS));
    s7_relw_r <= s6_relw_r;
    s7_den_r  <= s6_den_r;
  end

  // stage 8: row difference
  logic             s8_v_r;
  diff_t            s8_ta_r, s8_dt_r;
  logic [DEN_W-1:0] s8_relw_r, s8_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s8_v_r <= 1'b0;
    else        s8_v_r <= s7_v_r;
  end

  always_ff @(posedge clk) begin
    s8_ta_r   <= s7_ta_r;
    s8_dt_r   <= s7_tb_r - s7_ta_r;
    s8_relw_r <= s7_relw_r;
    s8_den_r  <= s7_den_r;
  end

  // stage 9: position in segment times row difference
  logic signed [DEN_W:0] relw_s;
  assign relw_s = signed'({1'b0, s8_relw_r});

  logic                    s9_v_r;
  diff_t                   s9_ta_r;
  logic signed [NUM_W-1:0] s9_num_r;
  logic [DEN_W-1:0]        s9_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s9_v_r <= 1'b0;
    else        s9_v_r <= s8_v_r;
  end

  always_ff @(posedge clk) begin
    s9_ta_r  <= s8_ta_r;
    s9_num_r <= NUM_W'(relw_s) * NUM_W'(s8_dt_r);
    s9_den_r <= s8_den_r;
  end

  // dividend (2*num + den) offset by a quotient bias so it stays positive
  logic signed [NW:0]  np_w;
  logic signed [NW:0]  den_w;
  logic [NW-1:0]       nprime;

  always_comb begin
    den_w  = (NW + 1)'(signed'({1'b0, s9_den_r}));
    np_w   = ((NW + 1)'(s9_num_r) <<< 1) + (den_w <<< QW) + den_w;
    nprime = np_w[NW-1:0];
  end

  // restoring divider, one quotient bit per stage
  logic             dv_v_r   [0:QW];
  logic [DW-1:0]    dv_rem_r [0:QW];
  logic [QW-1:0]    dv_nq_r  [0:QW];
  logic [DW-1:0]    dv_d_r   [0:QW];
  diff_t            dv_ta_r  [0:QW];
  logic [DW-1:0]    dv_rem_nxt [0:QW-1];
  logic [QW-1:0]    dv_nq_nxt  [0:QW-1];
  logic [DW:0]      dv_tr      [0:QW-1];
  logic             dv_ge      [0:QW-1];

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      dv_tr[j]      = {dv_rem_r[j], dv_nq_r[j][QW-1]};
      dv_ge[j]      = dv_tr[j] >= {1'b0, dv_d_r[j]};
      dv_rem_nxt[j] = dv_ge[j] ? DW'(dv_tr[j] - {1'b0, dv_d_r[j]}) : DW'(dv_tr[j]);
      dv_nq_nxt[j]  = {dv_nq_r[j][QW-2:0], dv_ge[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j <= QW; j++) dv_v_r[j] <= 1'b0;
    end else begin
      dv_v_r[0] <= s9_v_r;
      for (int j = 0; j < QW; j++) dv_v_r[j+1] <= dv_v_r[j];
    end
  end

  always_ff @(posedge clk) begin
    dv_rem_r[0] <= nprime[NW-1:QW];
    dv_nq_r[0]  <= nprime[QW-1:0];
    dv_d_r[0]   <= {s9_den_r, 1'b0};
    dv_ta_r[0]  <= s9_ta_r;
    for (int j = 0; j < QW; j++) begin
      dv_rem_r[j+1] <= dv_rem_nxt[j];
      dv_nq_r[j+1]  <= dv_nq_nxt[j];
      dv_d_r[j+1]   <= dv_d_r[j];
      dv_ta_r[j+1]  <= dv_ta_r[j];
    end
  end

  // remove quotient bias, saturate, output register
  logic signed [RW-1:0] res;
  data_t                res_sat;

  always_comb begin
    res = RW'(dv_ta_r[QW]) + RW'(signed'({1'b0, dv_nq_r[QW]})) - QOFS;
    priority if (res > RES_MAX) res_sat = data_t'(RES_MAX);
    else if (res < RES_MIN)     res_sat = data_t'(RES_MIN);
    else                        res_sat = data_t'(res);
  end

  logic  out_valid_r;
  data_t out_log_cooling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= dv_v_r[QW];
  end

  always_ff @(posedge clk) begin
    out_log_cooling_r <= res_sat;
  end

  assign out_valid       = out_valid_r;
  assign out_log_cooling = out_log_cooling_r;

  // checks
  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && (in_action == ACT_QUERY), LATENCY))
    else $error("result without a matching query");

  a_weight_in_segment: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !s3_wr_r) |-> ((s3_relw_r <= s3_den_r) && (s3_den_r != '0)))
    else $error("segment weight outside its segment");

  a_div_start_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[0] |-> (dv_rem_r[0] < dv_d_r[0]))
    else $error("divider quotient overflow");

  a_busy_in_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for cooling_table_interpolator_unit
// depends on clti_pkg and the unit; queued driver, clocked monitor, own predictor
`timescale 1ns / 1ps

module testbench;
  import clti_pkg::*;

  localparam int TPTS    = 91;
  localparam int FRAC    = 16;
  localparam int ROWS    = 8;
  localparam int LAT     = 37;
  localparam int WDOG    = 20000;
  localparam longint ONE  = 64'sd65536;
  localparam longint HALF = 64'sd32768;

  typedef struct packed {
    logic        action;
    logic [23:0] log_metal;
    logic [23:0] log_temp;
    logic [2:0]  row;
    logic [6:0]  column;
    logic [23:0] value;
  } word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = 1'b0;
  logic signed [23:0] in_log_metal = '0;
  logic signed [23:0] in_log_temp = '0;
  logic [2:0] in_entry_row = '0;
  logic [6:0] in_entry_column = '0;
  logic signed [23:0] in_entry_value = '0;
  logic out_valid;
  logic signed [23:0] out_log_cooling;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  cooling_table_interpolator_unit #(.TEMP_POINTS(TPTS), .FRAC_BITS(FRAC)) uut (.*);

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state
  longint rate_copy [ROWS*TPTS];
  bit     written [ROWS*TPTS];
  longint floor_reg = -1310720;
  longint solar_reg = -111411;

  word_t pending_words[$];
  logic [23:0] cooling_expected[$];
  int  errors = 0;
  int  send_idle_pct = 0;
  int  idle_cycles = 0;
  bit  stim_done = 0;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint round_lerp(longint a, longint num, longint den);
    return a + fdiv(2 * num + den, 2 * den);
  endfunction

  function automatic longint temp_lerp(int r, longint lt);
    longint x20, bin, rem, e1, e2;
    x20 = 20 * (lt - 4 * ONE);
    bin = fdiv(x20, ONE);
    if (bin <= 0) return rate_copy[r*TPTS];
    if (bin >= TPTS - 1) return rate_copy[r*TPTS + TPTS - 1];
    rem = x20 - bin * ONE;
    e1 = rate_copy[r*TPTS + bin];
    e2 = rate_copy[r*TPTS + bin + 1];
    return round_lerp(e1, rem * (e2 - e1), ONE);
  endfunction

  function automatic logic [23:0] cooling_of(word_t w);
    longint bp [8];
    longint rel, lt, t1, t2, res, den;
    int seg;
    rel = longint'($signed(w.log_metal)) - solar_reg;
    lt = longint'($signed(w.log_temp));
    seg = 0;
    bp = '{floor_reg, -3*ONE, -2*ONE, -3*HALF, -ONE, -HALF, 0, HALF};
    if (rel <= floor_reg) res = temp_lerp(0, lt);
    else if (rel > HALF) res = temp_lerp(ROWS - 1, lt);
    else begin
      for (int i = 6; i >= 0; i--)
        if (rel > bp[i] && rel <= bp[i+1]) seg = i;
      t1 = temp_lerp(seg, lt);
      t2 = temp_lerp(seg + 1, lt);
      den = bp[seg+1] - bp[seg];
      res = (den <= 0) ? t1 : round_lerp(t1, (rel - bp[seg]) * (t2 - t1), den);
    end
    if (res > 8388607) res = 8388607;
    if (res < -8388608) res = -8388608;
    return res[23:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // driver: one word per accepted start, random sender gaps
  always @(posedge clk) begin
    word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        w = pending_words.pop_front();
        if (w.action == ACT_WRITE) begin
          if (w.column < TPTS) begin
            rate_copy[w.row*TPTS + w.column] = longint'($signed(w.value));
            written[w.row*TPTS + w.column] = 1;
          end
        end else begin
          cooling_expected.push_back(cooling_of(w));
        end
      end
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words[0];
        start <= 1'b1;
        in_action <= w.action;
        in_log_metal <= w.log_metal;
        in_log_temp <= w.log_temp;
        in_entry_row <= w.row;
        in_entry_column <= w.column;
        in_entry_value <= w.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: compare each strobed word with the oldest expected
  always @(posedge clk) begin
    logic [23:0] exp_val;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else                               idle_cycles <= idle_cycles + 1;
      if (out_valid) begin
        if (cooling_expected.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_val = cooling_expected.pop_front();
          if (out_log_cooling !== exp_val)
            report_mismatch($sformatf("log_cooling got %h expected %h",
                                      out_log_cooling, exp_val));
        end
      end
      if (idle_cycles >= WDOG) begin
        $display("watchdog expired");
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // wait for the unit to drain
  task automatic drain();
    while (pending_words.size() != 0 || start || cooling_expected.size() != 0)
      @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[23:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_METAL_FLOOR) floor_reg = longint'($signed(val[23:0]));
    else solar_reg = longint'($signed(val[23:0]));
  endtask

  function automatic word_t entry_word(int r, int c, logic [23:0] v);
    word_t w;
    w = '0;
    w.log_metal = 24'($urandom);
    w.log_temp = 24'($urandom);
    w.action = ACT_WRITE;
    w.row = 3'(r);
    w.column = 7'(c);
    w.value = v;
    return w;
  endfunction

  function automatic word_t query_word(logic [23:0] m, logic [23:0] t);
    word_t w;
    w = '0;
    w.row = 3'($urandom);
    w.column = 7'($urandom);
    w.value = 24'($urandom);
    w.action = ACT_QUERY;
    w.log_metal = m;
    w.log_temp = t;
    return w;
  endfunction

  // random metallicity near breakpoints or anywhere
  function automatic logic [23:0] pick_metal();
    longint c;
    case ($urandom_range(3))
      0: c = $urandom;
      1: c = solar_reg + floor_reg + $signed($urandom_range(8, 0)) - 4;
      default: c = solar_reg + $signed($urandom_range(262144, 0)) - 229376;
    endcase
    return c[23:0];
  endfunction

  function automatic logic [23:0] pick_temp();
    longint c;
    case ($urandom_range(3))
      0: c = $urandom;
      1: c = 4 * ONE + fdiv(longint'($urandom_range(91)) * ONE, 20)
             + $signed($urandom_range(6, 0)) - 3;
      default: c = 4 * ONE + $urandom_range(300000);
    endcase
    return c[23:0];
  endfunction

  initial begin
    int r, c;
    logic [23:0] v;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole table so no query reads an unwritten entry
    for (r = 0; r < ROWS; r++)
      for (c = 0; c < TPTS; c++)
        pending_words.push_back(entry_word(r, c, 24'($urandom)));
    // ignored write with an out-of-range column
    pending_words.push_back(entry_word(3, 127, 24'h123456));
    // directed: extreme values and cases
    pending_words.push_back(entry_word(0, 0, 24'h7fffff));
    pending_words.push_back(entry_word(0, 1, 24'h800000));
    pending_words.push_back(entry_word(7, 90, 24'h800000));
    pending_words.push_back(query_word(24'h800000, 24'h800000));
    pending_words.push_back(query_word(24'h7fffff, 24'h7fffff));
    pending_words.push_back(query_word(24'h800000, 24'h7fffff));
    pending_words.push_back(query_word(24'h7fffff, 24'h800000));
    pending_words.push_back(query_word(24'(-111411 - 1310720), 24'h040ccd));
    pending_words.push_back(query_word(24'(-111411 + 32768), 24'h04199a));
    pending_words.push_back(query_word(24'(-111411 + 32769), 24'h040000));
    pending_words.push_back(query_word(24'(-111411 - 196608), 24'h0a0000));
    pending_words.push_back(query_word(24'(-111411 - 98304), 24'h0a7fff));
    pending_words.push_back(query_word(24'(-111411), 24'h050000));
    drain();

    // phases of register settings and sender idling
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin write_reg(CFG_METAL_FLOOR, -8388608); write_reg(CFG_SOLAR_OFFSET, 0); end
        1: begin write_reg(CFG_METAL_FLOOR, -786433); write_reg(CFG_SOLAR_OFFSET, 8388607); end
        2: begin write_reg(CFG_METAL_FLOOR, -1310720); write_reg(CFG_SOLAR_OFFSET, -8388608); end
        3: begin
          write_reg(CFG_METAL_FLOOR, -786433 - $urandom_range(7000000));
          write_reg(CFG_SOLAR_OFFSET, $signed($urandom_range(400000)) - 200000);
        end
        default: begin write_reg(CFG_METAL_FLOOR, -1310720); write_reg(CFG_SOLAR_OFFSET, -111411); end
      endcase
      send_idle_pct = (ph == 1) ? 82 : (ph == 3) ? 17 : 0;
      for (int k = 0; k < 130; k++) begin
        if ($urandom_range(9) < 2) begin
          r = $urandom_range(7);
          c = ($urandom_range(15) == 0) ? $urandom_range(127, 91) : $urandom_range(90);
          pending_words.push_back(entry_word(r, c, 24'($urandom)));
        end else begin
          pending_words.push_back(query_word(pick_metal(), pick_temp()));
        end
        // pause once until all results are back
        if (ph == 2 && k == 60) begin
          while (pending_words.size() != 0 || start || cooling_expected.size() != 0)
            @(posedge clk);
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
